### hw/rtl/rssr_pkg.sv
`timescale 1ns / 1ps
package rssr_pkg;

    localparam int COORD_W    = 20;
    localparam int REL_W      = COORD_W + 1;
    localparam int ROT_W      = COORD_W + 3;
    localparam int PH_W       = 16;
    localparam int CS_W       = 16;
    localparam int CX_W       = 19;
    localparam int Z_W        = 17;
    localparam int SLICE_W    = 5;
    localparam int CNT_W      = 6;
    localparam int K_W        = 4;
    localparam int PROD_W     = REL_W + CS_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int MAX_SLICES = 32;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 8'd3;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 19'sd19898;

    // 65536 / n, kept to 16 bits
    localparam logic [PH_W-1:0] STEP_TAB [0:MAX_SLICES] = '{
        16'd0, 16'd0, 16'd32768, 16'd21845, 16'd16384, 16'd13107, 16'd10922,
        16'd9362, 16'd8192, 16'd7281, 16'd6553, 16'd5957, 16'd5461, 16'd5041,
        16'd4681, 16'd4369, 16'd4096, 16'd3855, 16'd3640, 16'd3449, 16'd3276,
        16'd3120, 16'd2978, 16'd2849, 16'd2730, 16'd2621, 16'd2520, 16'd2427,
        16'd2340, 16'd2259, 16'd2184, 16'd2114, 16'd2048
    };

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_INIT   = 6'b000010,
        ST_CORD   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SUM    = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic               load;
        logic               cordic_init;
        logic               cordic_step;
        logic [K_W-1:0]     k;
        logic               mul;
        logic               sum;
        logic               next_slice;
        logic               emit;
        logic               mirror;
        logic               last;
        logic [SLICE_W-1:0] slice;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] n_eff;
        logic             mirror_en;
        logic             out_free;
    } sts_t;

    function automatic logic [Z_W-1:0] atan_of(input logic [K_W-1:0] k);
        logic [Z_W-1:0] a;
        begin
            a = '0;
            unique case (k)
                4'd0:  a = 17'd8192;
                4'd1:  a = 17'd4836;
                4'd2:  a = 17'd2555;
                4'd3:  a = 17'd1297;
                4'd4:  a = 17'd651;
                4'd5:  a = 17'd326;
                4'd6:  a = 17'd163;
                4'd7:  a = 17'd81;
                4'd8:  a = 17'd41;
                4'd9:  a = 17'd20;
                4'd10: a = 17'd10;
                4'd11: a = 17'd5;
                4'd12: a = 17'd3;
                4'd13: a = 17'd1;
                4'd14: a = 17'd1;
                default: a = 17'd0;
            endcase
            return a;
        end
    endfunction

    function automatic logic signed [CS_W-1:0] clamp16(input logic signed [CX_W:0] v);
        logic signed [CS_W-1:0] r;
        begin
            if (v > 20'sd32767)
                r = 16'sh7FFF;
            else if (v < -20'sd32768)
                r = 16'sh8000;
            else
                r = v[CS_W-1:0];
            return r;
        end
    endfunction

endpackage

### hw/rtl/rotational_symmetry_segment_replicator_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer moves
// s_axis    in         start_x, start_y, end_x, end_y (one segment)
// m_axis    out        four transformed coordinates, slice_index, is_mirror, last
// cfg       in         register index and write data
//
// One slice runs CORDIC seed, 16 CORDIC iterations, multiply, sum and emit;
// the mirrored copy adds another emit.
// A new segment is taken only after the last result of the previous one is loaded.
// rst_n clears configuration, controller and output valid asynchronously.
// A stalled m_axis holds the output register and pauses the sequencer.
module rotational_symmetry_segment_replicator_unit
    import rssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [4*COORD_W-1:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [4*COORD_W-1:0] m_axis_tdata,   // out_start_x, out_start_y, out_end_x, out_end_y
    output logic [SLICE_W:0]     m_axis_tuser,   // slice_index, is_mirror
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    rssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rssr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

### hw/rtl/rssr_ctrl.sv
`timescale 1ns / 1ps
module rssr_ctrl
    import rssr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t             state_reg, state_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic               mir_reg, mir_next;
    logic               final_slice;

    assign final_slice = ({1'b0, slice_reg} == (sts.n_eff - CNT_W'(1)));
    assign in_ready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        slice_next = slice_reg;
        mir_next   = mir_reg;
        cmd        = '0;
        cmd.k      = k_reg;
        cmd.slice  = slice_reg;
        cmd.mirror = mir_reg;
        cmd.last   = final_slice && (mir_reg || !sts.mirror_en);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && sts.n_eff != '0)
                begin
                    cmd.load   = 1'b1;
                    slice_next = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.cordic_init = 1'b1;
                k_next          = '0;
                mir_next        = 1'b0;
                state_next      = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.cordic_step = 1'b1;
                k_next          = k_reg + K_W'(1);
                if (k_reg == '1)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register frees up
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.mirror_en && !mir_reg)
                        mir_next = 1'b1;
                    else if (final_slice)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.next_slice = 1'b1;
                        slice_next     = slice_reg + SLICE_W'(1);
                        state_next     = ST_INIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            slice_reg <= '0;
            mir_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            slice_reg <= slice_next;
            mir_reg   <= mir_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit while output register busy");
    a_cord_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORD && k_reg != '1) |=> state_reg == ST_CORD)
        else $error("rotation loop cut short");
    a_mirror_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.mirror) |-> sts.mirror_en)
        else $error("mirror copy without mirroring");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_INIT && slice_reg == '0)
        else $error("load did not start a run");

endmodule

### hw/rtl/rssr_dp.sv
`timescale 1ns / 1ps
module rssr_dp
    import rssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_fire,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic [4*COORD_W-1:0] in_data,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [4*COORD_W-1:0] out_data,
    output logic [SLICE_W:0]     out_user,
    output logic                 out_last
);

    logic [CNT_W-1:0]          slice_count_reg;
    logic                      mirror_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;

    logic [PH_W-1:0]           step_reg, phase_reg;
    logic signed [REL_W-1:0]   rel_reg [4];
    logic [1:0]                q_reg;
    logic signed [CX_W-1:0]    x_reg, y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic signed [PROD_W-1:0]  prod_reg [8];
    logic signed [ROT_W-1:0]   rx_reg [2], ry_reg [2];

    logic                      out_valid_reg;
    logic [4*COORD_W-1:0]      out_data_reg;
    logic [SLICE_W:0]          out_user_reg;
    logic                      out_last_reg;

    logic [CNT_W-1:0]          n_eff;
    logic [PH_W-1:0]           t_ph;
    logic signed [CX_W-1:0]    xs, ys;
    logic signed [CS_W-1:0]    c_val, s_val;
    logic [4*COORD_W-1:0]      emit_data;

    assign n_eff = (slice_count_reg > CNT_W'(MAX_SLICES)) ? CNT_W'(MAX_SLICES)
                                                          : slice_count_reg;
    assign sts.n_eff     = n_eff;
    assign sts.mirror_en = mirror_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign t_ph = phase_reg + 16'h2000;
    assign xs   = x_reg >>> cmd.k;
    assign ys   = y_reg >>> cmd.k;

    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                c_val = clamp16(20'(x_reg));
                s_val = clamp16(20'(y_reg));
            end
            2'd1:
            begin
                c_val = clamp16(-20'(y_reg));
                s_val = clamp16(20'(x_reg));
            end
            2'd2:
            begin
                c_val = clamp16(-20'(x_reg));
                s_val = clamp16(-20'(y_reg));
            end
            default:
            begin
                c_val = clamp16(20'(y_reg));
                s_val = clamp16(-20'(x_reg));
            end
        endcase
    end

    // saturate center +/- rotated offset for both endpoints
    always_comb
    begin
        logic signed [ROT_W:0] px, py;
        for (int e = 0; e < 2; e++)
        begin
            if (cmd.mirror)
                px = (ROT_W+1)'(cx_reg) - (ROT_W+1)'(rx_reg[e]);
            else
                px = (ROT_W+1)'(cx_reg) + (ROT_W+1)'(rx_reg[e]);
            py = (ROT_W+1)'(cy_reg) + (ROT_W+1)'(ry_reg[e]);
            if (px > (ROT_W+1)'((1 <<< (COORD_W-1)) - 1))
                emit_data[2*e*COORD_W +: COORD_W] = {1'b0, {(COORD_W-1){1'b1}}};
            else if (px < -(ROT_W+1)'(1 <<< (COORD_W-1)))
                emit_data[2*e*COORD_W +: COORD_W] = {1'b1, {(COORD_W-1){1'b0}}};
            else
                emit_data[2*e*COORD_W +: COORD_W] = px[COORD_W-1:0];
            if (py > (ROT_W+1)'((1 <<< (COORD_W-1)) - 1))
                emit_data[(2*e+1)*COORD_W +: COORD_W] = {1'b0, {(COORD_W-1){1'b1}}};
            else if (py < -(ROT_W+1)'(1 <<< (COORD_W-1)))
                emit_data[(2*e+1)*COORD_W +: COORD_W] = {1'b1, {(COORD_W-1){1'b0}}};
            else
                emit_data[(2*e+1)*COORD_W +: COORD_W] = py[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= '0;
            mirror_reg      <= 1'b0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_SLICE_COUNT: slice_count_reg <= cfg_data[CNT_W-1:0];
                    REG_MIRROR:      mirror_reg      <= cfg_data[0];
                    REG_CENTER_X:    cx_reg          <= cfg_data;
                    REG_CENTER_Y:    cy_reg          <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            step_reg  <= STEP_TAB[n_eff];
            phase_reg <= '0;
            for (int j = 0; j < 4; j++)
            begin
                if (j % 2 == 0)
                    rel_reg[j] <= REL_W'($signed(in_data[j*COORD_W +: COORD_W]))
                                  - REL_W'(cx_reg);
                else
                    rel_reg[j] <= REL_W'($signed(in_data[j*COORD_W +: COORD_W]))
                                  - REL_W'(cy_reg);
            end
        end
        if (cmd.next_slice)
            phase_reg <= phase_reg + step_reg;
        if (cmd.cordic_init)
        begin
            q_reg <= t_ph[15:14];
            z_reg <= $signed({3'b000, t_ph[13:0]}) - 17'sd8192;
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - $signed(atan_of(cmd.k));
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + $signed(atan_of(cmd.k));
            end
        end
        if (cmd.mul)
        begin
            for (int e = 0; e < 2; e++)
            begin
                prod_reg[4*e]   <= PROD_W'(rel_reg[2*e]   * c_val);
                prod_reg[4*e+1] <= PROD_W'(rel_reg[2*e+1] * s_val);
                prod_reg[4*e+2] <= PROD_W'(rel_reg[2*e]   * s_val);
                prod_reg[4*e+3] <= PROD_W'(rel_reg[2*e+1] * c_val);
            end
        end
        if (cmd.sum)
        begin
            for (int e = 0; e < 2; e++)
            begin
                logic signed [SUM_W-1:0] vx, vy;
                vx = SUM_W'(prod_reg[4*e]) - SUM_W'(prod_reg[4*e+1]) + SUM_W'(16384);
                vy = SUM_W'(prod_reg[4*e+2]) + SUM_W'(prod_reg[4*e+3]) + SUM_W'(16384);
                rx_reg[e] <= vx[15 +: ROT_W];
                ry_reg[e] <= vy[15 +: ROT_W];
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= emit_data;
            out_user_reg <= {cmd.mirror, cmd.slice};
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule
